[rtl/core/smmcn_pkg.sv]
// Package for the sensor min/max calibration and percent normalization block.
// Holds item types, operation codes and shared constants; depends on nothing.
package smmcn_pkg;

    localparam int CHANNELS_DEF    = 5;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int LEVEL_BITS      = 7;

    localparam logic [LEVEL_BITS-1:0] PERCENT = LEVEL_BITS'(100);

    localparam logic [1:0] FUNC_CLEAR     = 2'd0;
    localparam logic [1:0] FUNC_CALIBRATE = 2'd1;
    localparam logic [1:0] FUNC_NORMALIZE = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  channel;
        logic [11:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic                  range_error;
    } out_item_t;

endpackage

[rtl/core/smmcn_div.sv]
// Restoring divider that forms the 7-bit percent quotient, one bit per cycle.
// Depends on smmcn_pkg for the quotient width.
module smmcn_div #(
    parameter int SAMPLE_BITS = smmcn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [SAMPLE_BITS+6:0]               prod,
    input  logic [SAMPLE_BITS-1:0]               span,
    output logic                                 done,
    output logic [smmcn_pkg::LEVEL_BITS-1:0]     quo
);

    localparam int DW = SAMPLE_BITS + 7;
    localparam int QW = smmcn_pkg::LEVEL_BITS;
    localparam int SW = $clog2(QW);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dv_reg;
    logic [QW-1:0] quo_reg;
    logic [SW-1:0] step_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          fits;

    assign fits = (rem_reg >= dv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == SW'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= prod;
            dv_reg  <= DW'(span) << (QW - 1);
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dv_reg;
            end
            quo_reg <= {quo_reg[QW-2:0], fits};
            dv_reg  <= dv_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[rtl/core/sensor_minmax_calibrate_normalize.sv]
// A normalize item that divides runs the check, 7 divide steps, quotient capture and output
// register load; the next item is taken after that load. One that ends without dividing
// goes from the check to the output load, or straight to it for a bad channel. Calibrate
// items write the extremes in the check state; clear and ignored items need only the idle
// state. A result waiting behind a stalled one holds the input. Reset and clear items drop the
// per-channel valid bits of the extremes memory at once. Depends on smmcn_pkg and smmcn_div.
module sensor_minmax_calibrate_normalize #(
    parameter int CHANNELS    = smmcn_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = smmcn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  smmcn_pkg::in_item_t  sample_item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output smmcn_pkg::out_item_t result_item
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SB   = SAMPLE_BITS;
    localparam int PW   = SAMPLE_BITS + 7;
    localparam int LW   = smmcn_pkg::LEVEL_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CHK  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUT  = 2'd3;

    logic [2*SB-1:0] ext_mem [CHANNELS];
    logic [CHANNELS-1:0] vld_reg;

    logic [1:0]      state_reg, state_next;
    logic [2*SB-1:0] rd_reg;
    logic            rd_vld_reg;
    logic [SB-1:0]   s_reg;
    logic [CH_W-1:0] idx_reg;
    logic            norm_reg;
    logic [LW-1:0]   lvl_reg, lvl_next;
    logic            err_reg, err_next;
    logic            result_valid_reg;
    smmcn_pkg::out_item_t result_item_reg;

    logic            accept;
    logic            ok;
    logic [CH_W-1:0] idx;
    logic [SB-1:0]   hi, lo, cal_max, cal_min, span;
    logic [PW-1:0]   prod;
    logic            div_start;
    logic            div_done;
    logic [LW-1:0]   div_quo;
    logic            load_out;
    logic            cal_write;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign ok           = (32'(sample_item.channel) < CHANNELS);
    assign idx          = CH_W'(sample_item.channel);

    assign hi      = rd_vld_reg ? rd_reg[2*SB-1:SB] : '0;
    assign lo      = rd_vld_reg ? rd_reg[SB-1:0] : '1;
    assign cal_max = (s_reg >= hi) ? s_reg : hi;
    assign cal_min = (s_reg <= lo) ? s_reg : lo;
    assign span    = hi - lo;
    assign prod    = PW'(s_reg - lo) * PW'(smmcn_pkg::PERCENT);

    assign cal_write = (state_reg == ST_CHK) && !norm_reg;
    assign load_out  = (state_reg == ST_PUT) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        err_next   = err_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && ok && (sample_item.func == smmcn_pkg::FUNC_CALIBRATE
                                     || sample_item.func == smmcn_pkg::FUNC_NORMALIZE))
                begin
                    state_next = ST_CHK;
                end
                else if (accept && !ok && sample_item.func == smmcn_pkg::FUNC_NORMALIZE)
                begin
                    lvl_next   = '0;
                    err_next   = 1'b1;
                    state_next = ST_PUT;
                end
            end
            ST_CHK:
            begin
                err_next = 1'b0;
                if (!norm_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (hi <= lo)
                begin
                    lvl_next   = '0;
                    err_next   = 1'b1;
                    state_next = ST_PUT;
                end
                else if (s_reg <= lo)
                begin
                    lvl_next   = '0;
                    state_next = ST_PUT;
                end
                else if (s_reg >= hi)
                begin
                    lvl_next   = smmcn_pkg::PERCENT;
                    state_next = ST_PUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    lvl_next   = div_quo;
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    smmcn_div #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .prod  (prod),
        .span  (span),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && sample_item.func == smmcn_pkg::FUNC_CLEAR)
            begin
                vld_reg <= '0;
            end
            else if (cal_write)
            begin
                vld_reg[idx_reg] <= 1'b1;
            end
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && ok)
        begin
            rd_reg     <= ext_mem[idx];
            rd_vld_reg <= vld_reg[idx];
        end
        if (cal_write)
        begin
            ext_mem[idx_reg] <= {cal_max, cal_min};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_reg    <= SB'(sample_item.sample);
            idx_reg  <= idx;
            norm_reg <= (sample_item.func == smmcn_pkg::FUNC_NORMALIZE);
        end
        lvl_reg <= lvl_next;
        err_reg <= err_next;
        if (load_out)
        begin
            result_item_reg.level       <= lvl_reg;
            result_item_reg.range_error <= err_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

endmodule
